@@ hdl/cdq_pkg.sv @@
// ---------------------------------------------------------------------------
// cdq_pkg
// Shared sizes, command codes and status codes for the circular deque.
// ---------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH   = 8;
  localparam int DATA_W  = 32;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;

  localparam logic [PTR_W-1:0] PTR_ZERO = '0;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  // Write and read request from the controller to the entry store
  typedef struct packed {
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
  } mem_req_t;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? PTR_ZERO : PTR_W'(p + 1'b1);
  endfunction

  function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p);
    return (p == PTR_ZERO) ? PTR_LAST : PTR_W'(p - 1'b1);
  endfunction

endpackage

@@ hdl/circular_deque_controller.sv @@
// ---------------------------------------------------------------------------
// circular_deque_controller
// Double-ended queue in a circular entry store with front/rear pointers.
// ---------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------
//  input   | in_command, in_push_value               | start & !busy
//  result  | out_result_value, out_status,           | out_valid, one cycle
//          | out_now_empty, out_now_full             |
//
// One command per cycle; each result appears in the cycle after its command,
// from the registered read of the entry store. busy stays low: a push
// writes the store at acceptance and a later read sees it. Reset empties the
// queue at once; the store itself is not cleared. Results cannot be stalled.
// ---------------------------------------------------------------------------
module circular_deque_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [cdq_pkg::CMD_W-1:0]         in_command,
  input  logic signed [cdq_pkg::DATA_W-1:0] in_push_value,
  output logic                              out_valid,
  output logic signed [cdq_pkg::DATA_W-1:0] out_result_value,
  output logic [cdq_pkg::STAT_W-1:0]        out_status,
  output logic                              out_now_empty,
  output logic                              out_now_full
);

  logic                       accept;
  cdq_pkg::mem_req_t          mem_req;
  logic [cdq_pkg::DATA_W-1:0] rd_data;
  logic                       res_use_mem;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  cdq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .command     (in_command),
    .push_value  (in_push_value),
    .mem_req     (mem_req),
    .res_valid   (out_valid),
    .res_use_mem (res_use_mem),
    .res_status  (out_status),
    .res_empty   (out_now_empty),
    .res_full    (out_now_full)
  );

  cdq_ram #(
    .WORDS  (cdq_pkg::DEPTH),
    .WIDTH  (cdq_pkg::DATA_W),
    .ADDR_W (cdq_pkg::PTR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  // zero the value for pushes, errors and unused codes
  assign out_result_value = res_use_mem ? $signed(rd_data) : '0;

endmodule

@@ hdl/cdq_ram.sv @@
// ---------------------------------------------------------------------------
// cdq_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ---------------------------------------------------------------------------
module cdq_ram #(
  parameter int WORDS  = 8,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [WORDS];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/cdq_ctrl.sv @@
// ---------------------------------------------------------------------------
// cdq_ctrl
// Pointer and flag keeper: decodes a command, checks the guards, issues the
// store access and registers status and flags for the result.
// ---------------------------------------------------------------------------
module cdq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [cdq_pkg::CMD_W-1:0]     command,
  input  logic [cdq_pkg::DATA_W-1:0]    push_value,
  output cdq_pkg::mem_req_t             mem_req,
  output logic                          res_valid,
  output logic                          res_use_mem,
  output logic [cdq_pkg::STAT_W-1:0]    res_status,
  output logic                          res_empty,
  output logic                          res_full
);

  logic [cdq_pkg::PTR_W-1:0]  front_r, front_nxt;
  logic [cdq_pkg::PTR_W-1:0]  rear_r, rear_nxt;
  logic                       empty_r, empty_nxt;
  logic                       full_now, full_nxt;
  logic                       valid_r, use_mem_r, use_mem_nxt;
  logic [cdq_pkg::STAT_W-1:0] status_r, status_nxt;
  logic                       o_empty_r, o_full_r;
  cdq_pkg::cmd_t              cmd;

  assign cmd      = cdq_pkg::cmd_t'(command);
  assign full_now = !empty_r && (cdq_pkg::wrap_inc(rear_r) == front_r);
  assign full_nxt = !empty_nxt && (cdq_pkg::wrap_inc(rear_nxt) == front_nxt);

  always_comb begin
    front_nxt       = front_r;
    rear_nxt        = rear_r;
    empty_nxt       = empty_r;
    status_nxt      = cdq_pkg::ST_OK;
    use_mem_nxt     = 1'b0;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = cdq_pkg::PTR_ZERO;
    mem_req.wr_data = push_value;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = front_r;
    unique case (cmd)
      cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR: begin
        if (full_now) begin
          status_nxt = cdq_pkg::ST_OVERFLOW;
        end else if (empty_r) begin
          // first entry always lands at slot zero
          front_nxt     = cdq_pkg::PTR_ZERO;
          rear_nxt      = cdq_pkg::PTR_ZERO;
          empty_nxt     = 1'b0;
          mem_req.wr_en = accept;
        end else if (cmd == cdq_pkg::CMD_PUSH_FRONT) begin
          front_nxt       = cdq_pkg::wrap_dec(front_r);
          mem_req.wr_en   = accept;
          mem_req.wr_addr = front_nxt;
        end else begin
          rear_nxt        = cdq_pkg::wrap_inc(rear_r);
          mem_req.wr_en   = accept;
          mem_req.wr_addr = rear_nxt;
        end
      end
      cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR, cdq_pkg::CMD_PEEK_FRONT: begin
        if (empty_r) begin
          status_nxt = cdq_pkg::ST_UNDERFLOW;
        end else begin
          use_mem_nxt   = 1'b1;
          mem_req.rd_en = accept;
          if (cmd == cdq_pkg::CMD_POP_REAR) begin
            mem_req.rd_addr = rear_r;
          end
          if (cmd != cdq_pkg::CMD_PEEK_FRONT) begin
            if (front_r == rear_r) begin
              // last entry gone: return to the reset position
              empty_nxt = 1'b1;
              front_nxt = cdq_pkg::PTR_ZERO;
              rear_nxt  = cdq_pkg::PTR_ZERO;
            end else if (cmd == cdq_pkg::CMD_POP_FRONT) begin
              front_nxt = cdq_pkg::wrap_inc(front_r);
            end else begin
              rear_nxt = cdq_pkg::wrap_dec(rear_r);
            end
          end
        end
      end
      default: begin
        // unused code: no effect, report current flags
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= cdq_pkg::PTR_ZERO;
      rear_r  <= cdq_pkg::PTR_ZERO;
      empty_r <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
      if (accept) begin
        front_r <= front_nxt;
        rear_r  <= rear_nxt;
        empty_r <= empty_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      use_mem_r <= use_mem_nxt;
      status_r  <= status_nxt;
      o_empty_r <= empty_nxt;
      o_full_r  <= full_nxt;
    end
  end

  assign res_valid   = valid_r;
  assign res_use_mem = use_mem_r;
  assign res_status  = status_r;
  assign res_empty   = o_empty_r;
  assign res_full    = o_full_r;

endmodule

@@ test/circular_deque_controller_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// circular_deque_controller_tb
// Drives push, pop and peek commands into the deque in bursts with random
// gaps. A scoreboard keeps its own copy of the queue, predicts each result
// when the command is accepted, and checks every result field by field.
// ---------------------------------------------------------------------------
module circular_deque_controller_tb;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_ITEMS   = 1550;
  localparam int MAX_GAP        = 8;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 500;

  // Codes outside the command set; the block must treat them as no-ops
  localparam logic [cdq_pkg::CMD_W-1:0] SPARE_CMD_A = 3'd5;
  localparam logic [cdq_pkg::CMD_W-1:0] SPARE_CMD_B = 3'd6;
  localparam logic [cdq_pkg::CMD_W-1:0] SPARE_CMD_C = 3'd7;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  typedef struct packed {
    logic signed [cdq_pkg::DATA_W-1:0] value;
    logic [cdq_pkg::STAT_W-1:0]        status;
    logic                              empty;
    logic                              full;
  } deque_result_t;

  class deque_scoreboard;
    logic [cdq_pkg::DATA_W-1:0] entries [cdq_pkg::DEPTH];
    logic [cdq_pkg::PTR_W-1:0]  head;
    logic [cdq_pkg::PTR_W-1:0]  tail;
    bit                         is_empty;
    deque_result_t              awaited [$];
    int                         errors;

    function new();
      foreach (entries[i]) entries[i] = '0;
      head     = '0;
      tail     = '0;
      is_empty = 1'b1;
      errors   = 0;
    endfunction

    function logic [cdq_pkg::PTR_W-1:0] step_up(logic [cdq_pkg::PTR_W-1:0] p);
      return cdq_pkg::PTR_W'((int'(p) + 1) % cdq_pkg::DEPTH);
    endfunction

    function logic [cdq_pkg::PTR_W-1:0] step_down(logic [cdq_pkg::PTR_W-1:0] p);
      return cdq_pkg::PTR_W'((int'(p) + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH);
    endfunction

    function bit at_capacity();
      return !is_empty && (step_up(tail) == head);
    endfunction

    function void make_empty();
      is_empty = 1'b1;
      head     = '0;
      tail     = '0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Predict the result of an accepted command and advance the queue copy
    function void note_command(logic [cdq_pkg::CMD_W-1:0] cmd,
                               logic [cdq_pkg::DATA_W-1:0] val);
      deque_result_t r;
      r = '0;
      r.status = cdq_pkg::ST_OK;
      case (cmd)
        cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR: begin
          if (at_capacity()) begin
            r.status = cdq_pkg::ST_OVERFLOW;
          end else if (is_empty) begin
            head       = '0;
            tail       = '0;
            is_empty   = 1'b0;
            entries[0] = val;
          end else if (cmd == cdq_pkg::CMD_PUSH_FRONT) begin
            head          = step_down(head);
            entries[head] = val;
          end else begin
            tail          = step_up(tail);
            entries[tail] = val;
          end
        end
        cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR, cdq_pkg::CMD_PEEK_FRONT: begin
          if (is_empty) begin
            r.status = cdq_pkg::ST_UNDERFLOW;
          end else if (cmd == cdq_pkg::CMD_PEEK_FRONT) begin
            r.value = entries[head];
          end else if (cmd == cdq_pkg::CMD_POP_FRONT) begin
            r.value = entries[head];
            if (head == tail) make_empty();
            else head = step_up(head);
          end else begin
            r.value = entries[tail];
            if (head == tail) make_empty();
            else tail = step_down(tail);
          end
        end
        default: begin
        end
      endcase
      r.empty = is_empty;
      r.full  = at_capacity();
      awaited.push_back(r);
    endfunction

    function void check_result(logic signed [cdq_pkg::DATA_W-1:0] value,
                               logic [cdq_pkg::STAT_W-1:0] status,
                               logic empty, logic full);
      deque_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with no command outstanding: value %0d status %0d",
                 $time, value, status);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (value !== want.value) begin
        $display("%0t: result value expected %0d, got %0d", $time, want.value, value);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, status);
        errors++;
      end
      if (empty !== want.empty) begin
        $display("%0t: empty flag expected %0b, got %0b", $time, want.empty, empty);
        errors++;
      end
      if (full !== want.full) begin
        $display("%0t: full flag expected %0b, got %0b", $time, want.full, full);
        errors++;
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic [cdq_pkg::CMD_W-1:0]         in_command;
  logic signed [cdq_pkg::DATA_W-1:0] in_push_value;
  logic                              out_valid;
  logic signed [cdq_pkg::DATA_W-1:0] out_result_value;
  logic [cdq_pkg::STAT_W-1:0]        out_status;
  logic                              out_now_empty;
  logic                              out_now_full;

  deque_scoreboard sb;
  int              burst_left;
  int              quiet_cycles;

  circular_deque_controller u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_now_empty    (out_now_empty),
    .out_now_full     (out_now_full)
  );

  always #CLK_HALF clk = ~clk;

  // Monitor both channels and watch for a stalled run
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_command(in_command, in_push_value);
      if (out_valid) sb.check_result(out_result_value, out_status, out_now_empty, out_now_full);
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Drop start for the pause; scramble the payload so the block must ignore it
  task automatic pause(input int n);
    start         <= 1'b0;
    in_command    <= cdq_pkg::CMD_W'($urandom);
    in_push_value <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  task automatic issue(input logic [cdq_pkg::CMD_W-1:0] cmd,
                       input logic [cdq_pkg::DATA_W-1:0] val);
    if (burst_left == 0) begin
      pause($urandom_range(1, MAX_GAP));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    start         <= 1'b1;
    in_command    <= cmd;
    in_push_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [cdq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Bias pushes against pops by mode so the queue swings between full and empty
  function automatic logic [cdq_pkg::CMD_W-1:0] pick_command(input int mode);
    int roll;
    int push_pct;
    roll     = $urandom_range(0, 99);
    push_pct = (mode == MODE_FILL) ? 75 : (mode == MODE_DRAIN) ? 25 : 50;
    if (roll < 3) return cdq_pkg::CMD_W'($urandom_range(SPARE_CMD_A, SPARE_CMD_C));
    if (roll < push_pct) begin
      return $urandom_range(0, 1) ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_REAR;
    end
    case ($urandom_range(0, 2))
      0:       return cdq_pkg::CMD_POP_FRONT;
      1:       return cdq_pkg::CMD_POP_REAR;
      default: return cdq_pkg::CMD_PEEK_FRONT;
    endcase
  endfunction

  initial begin
    int mode;
    int mode_left;
    sb            = new();
    burst_left    = 0;
    quiet_cycles  = 0;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_command    <= cdq_pkg::CMD_PUSH_FRONT;
    in_push_value <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Underflow and spare codes on the empty queue
    issue(cdq_pkg::CMD_PEEK_FRONT, 32'h1234_5678);
    issue(cdq_pkg::CMD_POP_FRONT, '0);
    issue(cdq_pkg::CMD_POP_REAR, '0);
    issue(SPARE_CMD_C, 32'hFFFF_FFFF);
    // Fill from both ends, first push into the empty queue
    issue(cdq_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    issue(cdq_pkg::CMD_PUSH_REAR, 32'h8000_0000);
    issue(cdq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    issue(cdq_pkg::CMD_PUSH_REAR, 32'h0000_0000);
    issue(cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0001);
    issue(cdq_pkg::CMD_PUSH_REAR, 32'h5555_5555);
    issue(cdq_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    issue(cdq_pkg::CMD_PUSH_REAR, 32'h0000_0002);
    // Overflow at both ends, spare code and peek while full
    issue(cdq_pkg::CMD_PUSH_FRONT, 32'hDEAD_BEEF);
    issue(cdq_pkg::CMD_PUSH_REAR, 32'hCAFE_F00D);
    issue(SPARE_CMD_A, 32'h0000_0000);
    issue(cdq_pkg::CMD_PEEK_FRONT, '0);
    // Drain from alternate ends until the queue is empty
    issue(cdq_pkg::CMD_POP_FRONT, '0);
    issue(cdq_pkg::CMD_POP_REAR, '0);
    issue(cdq_pkg::CMD_POP_FRONT, '0);
    issue(cdq_pkg::CMD_POP_REAR, '0);
    issue(cdq_pkg::CMD_POP_FRONT, '0);
    issue(cdq_pkg::CMD_POP_REAR, '0);
    issue(cdq_pkg::CMD_POP_FRONT, '0);
    issue(cdq_pkg::CMD_POP_REAR, '0);
    issue(SPARE_CMD_B, 32'h8000_0000);

    mode      = MODE_FILL;
    mode_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(MODE_FILL, MODE_MIXED);
        mode_left = $urandom_range(10, 40);
      end
      mode_left--;
      issue(pick_command(mode), pick_value());
    end

    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
